### sv/cbg_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbg_pkg: shared types, constants and sine table for the chirp burst generator
// Holds the register map, the front-to-back job record and the quarter-wave
// sine table, which is built when the design is elaborated.
// ----------------------------------------------------------------------------
package cbg_pkg;

	localparam int SINE_TABLE_BITS = 10;
	localparam int LENGTH_BITS     = 20;
	localparam int RAMP_BITS       = LENGTH_BITS - 1;
	localparam int TBL_SIZE        = 1 << SINE_TABLE_BITS;
	localparam int TBL_ADDR_BITS   = SINE_TABLE_BITS + 1;
	localparam int FREQ_BITS       = 31;
	localparam int FW_BITS         = 33;
	localparam int AMP_BITS        = 15;
	localparam int CFG_DATA_BITS   = 32;
	localparam int CFG_ADDR_BITS   = 3;
	localparam int JOB_DEPTH       = 2;
	localparam int JOB_PTR_BITS    = 1;
	localparam int JOB_CNT_BITS    = JOB_PTR_BITS + 1;

	// register indexes
	localparam logic [CFG_ADDR_BITS-1:0] REG_START_FREQ   = 3'd0;
	localparam logic [CFG_ADDR_BITS-1:0] REG_END_FREQ     = 3'd1;
	localparam logic [CFG_ADDR_BITS-1:0] REG_SWEEP_STEP   = 3'd2;
	localparam logic [CFG_ADDR_BITS-1:0] REG_BURST_LENGTH = 3'd3;
	localparam logic [CFG_ADDR_BITS-1:0] REG_RAMP_LENGTH  = 3'd4;
	localparam logic [CFG_ADDR_BITS-1:0] REG_WINDOW_STEP  = 3'd5;
	localparam logic [CFG_ADDR_BITS-1:0] REG_AMPLITUDE    = 3'd6;

	localparam logic [AMP_BITS-1:0] AMP_RESET = 15'h7FFF;

	typedef struct packed {
		logic [FREQ_BITS-1:0]   start_freq;
		logic [FREQ_BITS-1:0]   end_freq;
		logic [FREQ_BITS-1:0]   sweep_step;
		logic [LENGTH_BITS-1:0] burst_length;
		logic [RAMP_BITS-1:0]   ramp_length;
		logic [31:0]            window_step;
		logic [AMP_BITS-1:0]    amplitude;
	} cfg_t;

	// one classified sample, handed from the front to the back
	typedef struct packed {
		logic                 active;
		logic                 last;
		logic                 in_ramp;
		logic [RAMP_BITS-1:0] k;
		logic [31:0]          phase;
	} job_t;

	localparam logic [63:0] Q30_ONE     = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	typedef logic [AMP_BITS-1:0] quarter_tbl_t [0:TBL_SIZE];

	// round(32767 * sin(pi/2 * j / TBL_SIZE)) from a Q30 Taylor series
	function automatic logic [AMP_BITS-1:0] sine_entry(input int unsigned j);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		logic [63:0] e;
		x  = (64'(j) * HALF_PI_Q30) >> SINE_TABLE_BITS;
		x2 = (x * x) >> 30;
		t  = Q30_ONE;
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
		t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
		s  = (x * t) >> 30;
		e  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
		if (e > 64'd32767) begin
			e = 64'd32767;
		end
		return e[AMP_BITS-1:0];
	endfunction

	function automatic quarter_tbl_t build_quarter();
		quarter_tbl_t tbl;
		for (int j = 0; j <= TBL_SIZE; j++) begin
			tbl[j] = sine_entry(j);
		end
		return tbl;
	endfunction

	localparam quarter_tbl_t QUARTER_TABLE = build_quarter();

endpackage
`default_nettype wire

### sv/cbg_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbg_front: burst sequencing front end
// Accepts tick transactions, tracks the burst (phase, frequency word, index,
// direction) and classifies each sample into a job for the back end.
// ----------------------------------------------------------------------------
module cbg_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic          start_req,
	input  wire logic          sweep_up,
	input  wire cbg_pkg::cfg_t cfg,
	input  wire logic          q_full,
	output logic               full,
	output logic               q_push,
	output cbg_pkg::job_t      q_job
);

	logic [31:0]                         phase_acc_q;
	logic [cbg_pkg::FW_BITS-1:0]         freq_word_q;
	logic [cbg_pkg::LENGTH_BITS-1:0]     sample_index_q;
	logic                                running_q;
	logic                                down_sweep_q;

	logic                                accept;
	logic                                start_go;
	logic                                run;
	logic                                down;
	logic [31:0]                         phase;
	logic [cbg_pkg::FW_BITS-1:0]         fw;
	logic [cbg_pkg::FW_BITS-1:0]         fw_init;
	logic [cbg_pkg::FW_BITS-1:0]         half_step;
	logic [cbg_pkg::LENGTH_BITS-1:0]     idx;
	logic [cbg_pkg::LENGTH_BITS-1:0]     n;
	logic [cbg_pkg::RAMP_BITS-1:0]       half_n;
	logic [cbg_pkg::RAMP_BITS-1:0]       r;
	logic [cbg_pkg::LENGTH_BITS:0]       idx_plus_r;
	logic [cbg_pkg::LENGTH_BITS:0]       idx_plus_1;
	logic [cbg_pkg::LENGTH_BITS-1:0]     tail_k;
	logic                                head_ramp;
	logic                                in_ramp;
	logic                                last;
	logic [cbg_pkg::RAMP_BITS-1:0]       k;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign n      = cfg.burst_length;

	always_comb begin
		half_step = cbg_pkg::FW_BITS'(cfg.sweep_step >> 1);
		if (!sweep_up) begin
			fw_init = cbg_pkg::FW_BITS'(cfg.end_freq) - half_step;
		end else begin
			fw_init = cbg_pkg::FW_BITS'(cfg.start_freq) + half_step;
		end
		start_go = start_req && (n != '0);
		// a start with a zero length drops any burst in flight
		run   = start_req ? start_go : running_q;
		down  = start_go ? !sweep_up : down_sweep_q;
		phase = start_go ? '0 : phase_acc_q;
		fw    = start_go ? fw_init : freq_word_q;
		idx   = start_go ? '0 : sample_index_q;

		half_n = n[cbg_pkg::LENGTH_BITS-1:1];
		r      = (cfg.ramp_length > half_n) ? half_n : cfg.ramp_length;
		idx_plus_r = {1'b0, idx} + (cbg_pkg::LENGTH_BITS+1)'(r);
		idx_plus_1 = {1'b0, idx} + 1'b1;
		head_ramp  = idx < cbg_pkg::LENGTH_BITS'(r);
		in_ramp    = (r != '0) && (head_ramp || (idx_plus_r >= {1'b0, n}));
		tail_k     = (idx < n) ? (n - 1'b1 - idx) : '0;
		k          = head_ramp ? idx[cbg_pkg::RAMP_BITS-1:0]
		                       : tail_k[cbg_pkg::RAMP_BITS-1:0];
		last       = idx_plus_1 >= {1'b0, n};

		q_push        = accept;
		q_job.active  = run;
		q_job.last    = run && last;
		q_job.in_ramp = in_ramp;
		q_job.k       = k;
		q_job.phase   = phase;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q    <= '0;
			freq_word_q    <= '0;
			sample_index_q <= '0;
			running_q      <= 1'b0;
			down_sweep_q   <= 1'b0;
		end else if (accept) begin
			running_q    <= run && !last;
			down_sweep_q <= down;
			if (run) begin
				phase_acc_q    <= phase + fw[31:0];
				freq_word_q    <= down ? fw - cbg_pkg::FW_BITS'(cfg.sweep_step)
				                       : fw + cbg_pkg::FW_BITS'(cfg.sweep_step);
				sample_index_q <= idx_plus_1[cbg_pkg::LENGTH_BITS-1:0];
			end
		end
	end

endmodule
`default_nettype wire

### sv/cbg_job_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbg_job_queue: short job queue between front and back
// Register FIFO that lets the front keep accepting ticks while the back
// works through a sample.
// ----------------------------------------------------------------------------
module cbg_job_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire cbg_pkg::job_t push_job,
	output logic               full,
	input  wire logic          pop,
	output logic               empty,
	output cbg_pkg::job_t      head
);

	cbg_pkg::job_t                      entry_q [cbg_pkg::JOB_DEPTH];
	logic [cbg_pkg::JOB_PTR_BITS-1:0]   wr_ptr_q;
	logic [cbg_pkg::JOB_PTR_BITS-1:0]   rd_ptr_q;
	logic [cbg_pkg::JOB_CNT_BITS-1:0]   count_q;
	logic                               do_push;
	logic                               do_pop;

	assign full    = count_q == cbg_pkg::JOB_CNT_BITS'(cbg_pkg::JOB_DEPTH);
	assign empty   = count_q == '0;
	assign head    = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### sv/cbg_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbg_back: sample synthesis back end
// Four-step sequencer around one registered quarter-wave table port: sine of
// the carrier, cosine of the window angle, gain, scaled sample into the
// output register.
// ----------------------------------------------------------------------------
module cbg_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          q_empty,
	input  wire cbg_pkg::job_t                 q_head,
	output logic                               q_pop,
	input  wire logic [31:0]                   window_step,
	input  wire logic [cbg_pkg::AMP_BITS-1:0]  amplitude,
	input  wire logic                          pop,
	output logic                               empty,
	output logic signed [15:0]                 sample,
	output logic                               active,
	output logic                               last
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SIN  = 5'b00010,
		ST_COS  = 5'b00100,
		ST_GAIN = 5'b01000,
		ST_MUL  = 5'b10000
	} bk_state_t;

	bk_state_t                              state_q;
	bk_state_t                              state_d;
	cbg_pkg::job_t                          job_q;
	logic [31:0]                            wphase_q;
	logic [cbg_pkg::AMP_BITS-1:0]           lut_q;
	logic                                   lneg_q;
	logic [cbg_pkg::AMP_BITS-1:0]           sin_mag_q;
	logic                                   sin_neg_q;
	logic [cbg_pkg::AMP_BITS-1:0]           gain_q;
	logic                                   out_valid_q;
	logic signed [15:0]                     sample_q;
	logic                                   active_q;
	logic                                   last_q;

	logic                                   load_job;
	logic                                   emit;
	logic                                   slot_free;
	logic [31:0]                            lut_phase;
	logic [cbg_pkg::SINE_TABLE_BITS-1:0]    lut_idx;
	logic [cbg_pkg::TBL_ADDR_BITS-1:0]      lut_addr;
	logic [15:0]                            wsum;
	logic [cbg_pkg::AMP_BITS-1:0]           win;
	logic [29:0]                            gain_sum;
	logic [29:0]                            res_sum;
	logic [cbg_pkg::AMP_BITS-1:0]           res;
	logic [15:0]                            mag16;

	assign slot_free = !out_valid_q || pop;

	always_comb begin
		state_d  = state_q;
		load_job = 1'b0;
		emit     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					load_job = 1'b1;
					state_d  = ST_SIN;
				end
			end
			ST_SIN:  state_d = ST_COS;
			ST_COS:  state_d = ST_GAIN;
			ST_GAIN: state_d = ST_MUL;
			ST_MUL: begin
				// hold the finished sample until the output register frees up
				if (slot_free) begin
					emit = 1'b1;
					if (!q_empty) begin
						load_job = 1'b1;
						state_d  = ST_SIN;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
		q_pop = load_job;
	end

	// one table port: carrier phase in ST_SIN, window angle plus a quarter turn otherwise
	always_comb begin
		lut_phase = (state_q == ST_SIN) ? job_q.phase : wphase_q + 32'h4000_0000;
		lut_idx   = lut_phase[29 -: cbg_pkg::SINE_TABLE_BITS];
		lut_addr  = lut_phase[30] ? cbg_pkg::TBL_ADDR_BITS'(cbg_pkg::TBL_SIZE) - {1'b0, lut_idx}
		                          : {1'b0, lut_idx};
		wsum      = lneg_q ? 16'h8000 + {1'b0, lut_q} : 16'h8000 - {1'b0, lut_q};
		win       = job_q.in_ramp ? wsum[15:1] : 15'h7FFF;
		gain_sum  = 30'(amplitude) * 30'(win) + 30'd16384;
		res_sum   = 30'(gain_q) * 30'(sin_mag_q) + 30'd16384;
		res       = res_sum[29:15];
		mag16     = {1'b0, res};
	end

	always_ff @(posedge clk) begin
		lut_q  <= cbg_pkg::QUARTER_TABLE[lut_addr];
		lneg_q <= lut_phase[31];
		if (load_job) begin
			job_q <= q_head;
		end
		if (state_q == ST_SIN) begin
			wphase_q <= 32'(51'(job_q.k) * 51'(window_step));
		end
		if (state_q == ST_COS) begin
			sin_mag_q <= lut_q;
			sin_neg_q <= lneg_q;
		end
		if (state_q == ST_GAIN) begin
			gain_q <= gain_sum[29:15];
		end
		if (emit) begin
			active_q <= job_q.active;
			last_q   <= job_q.last;
			if (!job_q.active) begin
				sample_q <= '0;
			end else begin
				sample_q <= sin_neg_q ? -$signed(mag16) : $signed(mag16);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty  = !out_valid_q;
	assign sample = sample_q;
	assign active = active_q;
	assign last   = last_q;

endmodule
`default_nettype wire

### sv/chirp_burst_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// chirp_burst_generator: Tukey-windowed linear chirp burst source
// Top level: register file, front end, job queue and back end.
// ----------------------------------------------------------------------------
// Every push transaction is one sample tick and yields exactly one result on
// the pop side, in order. The front end takes one tick per clock while its
// two-entry job queue has room; the back end computes each sample in order,
// one step of its sequencer after another around the single registered port
// of the quarter-wave sine table (carrier sine, window cosine, gain, scaling),
// and takes the next job only once it has handed the finished sample to the
// output register. The output register keeps a finished sample while the
// next one is computed. Write configuration only while no transaction is in
// flight.
module chirp_burst_generator (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic                               start_req,
	input  wire logic                               sweep_up,
	output logic                                    empty,
	input  wire logic                               pop,
	output logic signed [15:0]                      sample,
	output logic                                    active,
	output logic                                    last,
	input  wire logic                               cfg_we,
	input  wire logic [cbg_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
	input  wire logic [cbg_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	cbg_pkg::cfg_t cfg_q;
	logic          q_full;
	logic          q_push;
	cbg_pkg::job_t q_job;
	logic          q_pop;
	logic          q_empty;
	cbg_pkg::job_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{
				start_freq:   '0,
				end_freq:     '0,
				sweep_step:   '0,
				burst_length: '0,
				ramp_length:  '0,
				window_step:  '0,
				amplitude:    cbg_pkg::AMP_RESET
			};
		end else if (cfg_we) begin
			case (cfg_addr)
				cbg_pkg::REG_START_FREQ:
					cfg_q.start_freq <= cfg_data[cbg_pkg::FREQ_BITS-1:0];
				cbg_pkg::REG_END_FREQ:
					cfg_q.end_freq <= cfg_data[cbg_pkg::FREQ_BITS-1:0];
				cbg_pkg::REG_SWEEP_STEP:
					cfg_q.sweep_step <= cfg_data[cbg_pkg::FREQ_BITS-1:0];
				cbg_pkg::REG_BURST_LENGTH:
					cfg_q.burst_length <= cfg_data[cbg_pkg::LENGTH_BITS-1:0];
				cbg_pkg::REG_RAMP_LENGTH:
					cfg_q.ramp_length <= cfg_data[cbg_pkg::RAMP_BITS-1:0];
				cbg_pkg::REG_WINDOW_STEP:
					cfg_q.window_step <= cfg_data;
				cbg_pkg::REG_AMPLITUDE:
					cfg_q.amplitude <= cfg_data[cbg_pkg::AMP_BITS-1:0];
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	cbg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.start_req (start_req),
		.sweep_up  (sweep_up),
		.cfg       (cfg_q),
		.q_full    (q_full),
		.full      (full),
		.q_push    (q_push),
		.q_job     (q_job)
	);

	cbg_job_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (q_job),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	cbg_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.window_step (cfg_q.window_step),
		.amplitude   (cfg_q.amplitude),
		.pop         (pop),
		.empty       (empty),
		.sample      (sample),
		.active      (active),
		.last        (last)
	);

endmodule
`default_nettype wire

### sv/cbg_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbg_checker: port-level checks for the chirp burst generator
// Watches the result side of the top level over time; bound to every instance.
// ----------------------------------------------------------------------------
module cbg_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               empty,
	input  wire logic                               pop,
	input  wire logic signed [15:0]                 sample,
	input  wire logic                               active,
	input  wire logic                               last
);

	// a waiting transaction holds its payload until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(sample) && $stable(active) && $stable(last)))
		else $error("result changed while waiting");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !active) |-> (sample == 16'sd0 && !last))
		else $error("idle result carries a sample or last");

	a_last_active: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && last) |-> active)
		else $error("last outside a burst");

	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (sample != 16'sh8000))
		else $error("sample beyond the saturation limit");

endmodule

bind chirp_burst_generator cbg_checker u_cbg_checker (.*);
`default_nettype wire
